### rtl/front_middle_back_queue_macros.svh
// Assertion macros for the front-middle-back queue checker.
// No dependencies; included by the files that assert.
`ifndef FRONT_MIDDLE_BACK_QUEUE_MACROS_SVH
`define FRONT_MIDDLE_BACK_QUEUE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FBQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FBQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/fbq_pkg.sv
// Shared types and codes of the front-middle-back queue.
// No dependencies; imported by the top level, the sequencer and the checker.
package fbq_pkg;

  // Command codes carried on in_tuser
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT  = 3'd0,
    CMD_PUSH_MIDDLE = 3'd1,
    CMD_PUSH_BACK   = 3'd2,
    CMD_POP_FRONT   = 3'd3,
    CMD_POP_MIDDLE  = 3'd4,
    CMD_POP_BACK    = 3'd5
  } cmd_t;

  // Result status codes carried on out_tuser
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // One result transaction
  typedef struct packed {
    logic [6:0]         item_count;
    status_t            status;
    logic signed [31:0] pop_value;
  } result_t;

endpackage

### rtl/front_middle_back_queue.sv
// Top level of the front-middle-back queue: two ring-buffer RAM halves, the
// sequencer and the result register. Depends on fbq_pkg, fbq_ram, fbq_ctrl.
//
//  channel | direction | tdata (low bit up)                 | tuser
//  in_     | slave     | push_value[31:0]                   | cmd[2:0]
//  out_    | master    | pop_value[31:0], item_count[38:32] | status[1:0]
//
// The accept cycle, in S_IDLE, issues the reads of both RAM halves; in S_EXEC
// the registered read data is used and written back once the result slot is
// free. Commands are taken only in S_IDLE, so a read-then-write pass ends
// before the next command. Reset is synchronous, active low, and clears state,
// pointers and counts; RAM contents are left as they are. A stalled output
// holds its result; one more command is accepted meanwhile and waits to execute.
module front_middle_back_queue #(
  parameter int HALF_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // push_value[31:0]
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // pop_value[31:0], item_count[38:32], zero[39]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import fbq_pkg::*;

  localparam int AW = $clog2(HALF_DEPTH);

  logic          rd_en, l_we, r_we, res_valid, res_ready;
  logic [AW-1:0] l_raddr, r_raddr, l_waddr, r_waddr;
  logic [31:0]   l_rdata, r_rdata, l_wdata, r_wdata;
  result_t       res;
  logic          out_valid_r;
  result_t       out_res_r;

  fbq_ctrl #(.HALF_DEPTH(HALF_DEPTH), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_value  (in_tdata),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .rd_en     (rd_en),
    .l_raddr   (l_raddr),
    .r_raddr   (r_raddr),
    .l_rdata   (l_rdata),
    .r_rdata   (r_rdata),
    .l_we      (l_we),
    .l_waddr   (l_waddr),
    .l_wdata   (l_wdata),
    .r_we      (r_we),
    .r_waddr   (r_waddr),
    .r_wdata   (r_wdata)
  );

  fbq_ram #(.DEPTH(HALF_DEPTH), .AW(AW)) u_left_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (rd_en),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  fbq_ram #(.DEPTH(HALF_DEPTH), .AW(AW)) u_right_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .re    (rd_en),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // Result slot is free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  // Output register: load a new result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.item_count, out_res_r.pop_value};
  assign out_tuser  = out_res_r.status;

endmodule

### rtl/fbq_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies; instantiated twice by the queue top level.
module fbq_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/fbq_ctrl.sv
// Sequencer of the front-middle-back queue: ring pointers, RAM addressing,
// read-modify-write of both halves and result build. Depends on fbq_pkg.
module fbq_ctrl #(
  parameter int HALF_DEPTH = 32,
  parameter int AW         = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic [31:0]        in_value,
  input  logic               res_ready,
  output logic               res_valid,
  output fbq_pkg::result_t   res,
  output logic               rd_en,
  output logic [AW-1:0]      l_raddr,
  output logic [AW-1:0]      r_raddr,
  input  logic [31:0]        l_rdata,
  input  logic [31:0]        r_rdata,
  output logic               l_we,
  output logic [AW-1:0]      l_waddr,
  output logic [31:0]        l_wdata,
  output logic               r_we,
  output logic [AW-1:0]      r_waddr,
  output logic [31:0]        r_wdata
);
  import fbq_pkg::*;

  localparam int CW = $clog2(HALF_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(HALF_DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(HALF_DEPTH);
  localparam logic [SW-1:0] FULL_S   = SW'(2 * HALF_DEPTH);

  state_t        state_r, state_nxt;
  logic [2:0]    cmd_r;
  logic [31:0]   val_r;
  logic [AW-1:0] lh_r, lh_nxt, rh_r, rh_nxt;
  logic [CW-1:0] lc_r, lc_nxt, rc_r, rc_nxt;
  logic [SW-1:0] total;
  logic          commit;

  // Ring index helpers
  function automatic logic [AW-1:0] idx_wrap(input logic [SW-1:0] s);
    return (s >= DEPTH_S) ? AW'(s - DEPTH_S) : AW'(s);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] h);
    return (h == '0) ? LAST_IDX : (h - AW'(1));
  endfunction

  function automatic logic [AW-1:0] idx_tail(input logic [AW-1:0] h, input logic [CW-1:0] c);
    return idx_wrap(SW'(h) + SW'(c));
  endfunction

  function automatic logic [AW-1:0] idx_back(input logic [AW-1:0] h, input logic [CW-1:0] c);
    return idx_wrap(SW'(h) + SW'(c) - SW'(1));
  endfunction

  assign in_ready = (state_r == S_IDLE) && rst_n;
  assign rd_en    = in_valid && in_ready;
  assign total    = SW'(lc_r) + SW'(rc_r);

  // Read addresses: left front for pop front, otherwise left back;
  // right back for pop back, otherwise right front
  assign l_raddr = (in_cmd == CMD_POP_FRONT) ? lh_r : idx_back(lh_r, lc_r);
  assign r_raddr = (in_cmd == CMD_POP_BACK) ? idx_back(rh_r, rc_r) : rh_r;

  // Latch the transaction at accept
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cmd_r <= in_cmd;
      val_r <= in_value;
    end
  end

  // State and pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lh_r    <= '0;
      rh_r    <= '0;
      lc_r    <= '0;
      rc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        lh_r <= lh_nxt;
        rh_r <= rh_nxt;
        lc_r <= lc_nxt;
        rc_r <= rc_nxt;
      end
    end
  end

  // Next state
  always_comb begin
    commit    = (state_r == S_EXEC) && res_ready;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (rd_en) state_nxt = S_EXEC;
      S_EXEC: if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Execute: modify pointers, write back both halves, build the result
  always_comb begin
    logic lw, rw;
    lw            = 1'b0;
    rw            = 1'b0;
    l_waddr       = idx_tail(lh_r, lc_r);
    l_wdata       = val_r;
    r_waddr       = idx_dec(rh_r);
    r_wdata       = val_r;
    lh_nxt        = lh_r;
    rh_nxt        = rh_r;
    lc_nxt        = lc_r;
    rc_nxt        = rc_r;
    res.status    = ST_OK;
    res.pop_value = '0;
    unique case (cmd_r)
      CMD_PUSH_FRONT: begin
        if (total == FULL_S) begin
          res.status = ST_FULL;
        end else if (lc_r == rc_r && lc_r == '0) begin
          // empty queue: the item lands at the right front
          rw     = 1'b1;
          rh_nxt = idx_dec(rh_r);
          rc_nxt = rc_r + CW'(1);
        end else if (lc_r == rc_r) begin
          // push at left front, move left back across to right front
          lw      = 1'b1;
          l_waddr = idx_dec(lh_r);
          lh_nxt  = idx_dec(lh_r);
          rw      = 1'b1;
          r_wdata = l_rdata;
          rh_nxt  = idx_dec(rh_r);
          rc_nxt  = rc_r + CW'(1);
        end else begin
          lw      = 1'b1;
          l_waddr = idx_dec(lh_r);
          lh_nxt  = idx_dec(lh_r);
          lc_nxt  = lc_r + CW'(1);
        end
      end
      CMD_PUSH_MIDDLE: begin
        if (total == FULL_S) begin
          res.status = ST_FULL;
        end else if (lc_r < rc_r) begin
          lw     = 1'b1;
          lc_nxt = lc_r + CW'(1);
        end else begin
          rw     = 1'b1;
          rh_nxt = idx_dec(rh_r);
          rc_nxt = rc_r + CW'(1);
        end
      end
      CMD_PUSH_BACK: begin
        r_waddr = idx_tail(rh_r, rc_r);
        if (total == FULL_S) begin
          res.status = ST_FULL;
        end else if (rc_r > lc_r) begin
          // move right front to left back, then push at right back
          lw      = 1'b1;
          l_wdata = r_rdata;
          lc_nxt  = lc_r + CW'(1);
          rw      = 1'b1;
          rh_nxt  = idx_wrap(SW'(rh_r) + SW'(1));
        end else begin
          rw     = 1'b1;
          rc_nxt = rc_r + CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (total == '0) begin
          res.status = ST_EMPTY;
        end else if (lc_r != '0) begin
          res.pop_value = l_rdata;
          lh_nxt        = idx_wrap(SW'(lh_r) + SW'(1));
          if (rc_r > lc_r) begin
            // refill left back from right front; left count holds
            lw      = 1'b1;
            l_wdata = r_rdata;
            rh_nxt  = idx_wrap(SW'(rh_r) + SW'(1));
            rc_nxt  = rc_r - CW'(1);
          end else begin
            lc_nxt = lc_r - CW'(1);
          end
        end else begin
          res.pop_value = r_rdata;
          rh_nxt        = idx_wrap(SW'(rh_r) + SW'(1));
          rc_nxt        = rc_r - CW'(1);
        end
      end
      CMD_POP_MIDDLE: begin
        if (total == '0) begin
          res.status = ST_EMPTY;
        end else if (lc_r == rc_r) begin
          res.pop_value = l_rdata;
          lc_nxt        = lc_r - CW'(1);
        end else begin
          res.pop_value = r_rdata;
          rh_nxt        = idx_wrap(SW'(rh_r) + SW'(1));
          rc_nxt        = rc_r - CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (total == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.pop_value = r_rdata;
          if (lc_r == rc_r) begin
            // refill right front from left back; right count holds
            rw      = 1'b1;
            r_wdata = l_rdata;
            rh_nxt  = idx_dec(rh_r);
            lc_nxt  = lc_r - CW'(1);
          end else begin
            rc_nxt = rc_r - CW'(1);
          end
        end
      end
      default: begin
        // unused command: no operation
      end
    endcase
    l_we           = lw && commit;
    r_we           = rw && commit;
    res.item_count = 7'(SW'(lc_nxt) + SW'(rc_nxt));
  end

  assign res_valid = commit;

endmodule

### rtl/fbq_checker.sv
// Port-level checker of the front-middle-back queue, bound to the top level.
// Depends on fbq_pkg and front_middle_back_queue_macros.svh.
`include "front_middle_back_queue_macros.svh"

module fbq_checker #(
  parameter int HALF_DEPTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import fbq_pkg::*;

  localparam logic [6:0] FULL_COUNT = 7'(2 * HALF_DEPTH);

  // Hold off the input for the cycle after each accepted transaction
  `FBQ_ASSERT(a_in_gap, in_tvalid && in_tready |=> !in_tready, "input ready right after accept")

  // Hold a stalled result transaction
  `FBQ_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // An empty pop reports no value and no items
  `FBQ_ASSERT(a_empty_pop, out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[38:0] == '0, "empty pop with data or items")

  // A rejected push reports a full queue and no value
  `FBQ_ASSERT(a_full_push, out_tvalid && out_tuser == ST_FULL |-> out_tdata[38:32] == FULL_COUNT && out_tdata[31:0] == '0, "full status with wrong count")

  // Drop any pending result on reset
  `FBQ_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind front_middle_back_queue fbq_checker #(.HALF_DEPTH(HALF_DEPTH)) u_fbq_checker (.*);
